@@ sv/lsb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_pkg: shared types and constants for the lit surface block shader
// Transaction structs, mode codes and block size helpers.
// ----------------------------------------------------------------------------
package lsb_pkg;

    localparam int BASE_BLOCK_SIZE_DEF = 16;
    localparam int CMAP_DEPTH          = 16384;
    localparam int CMAP_AW             = 14;
    localparam int CMAP_DW             = 8;
    localparam int CORNER_W            = 14;
    localparam int LIGHT_W             = 16;
    localparam int MIP_W               = 2;
    localparam int SHIFT_W             = 3;

    localparam logic [1:0] MODE_CMAP_WRITE  = 2'd0;
    localparam logic [1:0] MODE_BLOCK_START = 2'd1;
    localparam logic [1:0] MODE_TEXEL       = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [CMAP_AW-1:0]  cmap_index;
        logic [CMAP_DW-1:0]  cmap_value;
        logic [CORNER_W-1:0] light_top_left;
        logic [CORNER_W-1:0] light_top_right;
        logic [CORNER_W-1:0] light_bottom_left;
        logic [CORNER_W-1:0] light_bottom_right;
        logic [7:0]          texel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] shaded_pixel;
        logic       block_last;
    } out_item_t;

    typedef struct packed {
        logic [CMAP_AW-1:0] addr;
        logic               last;
    } lookup_t;

    // block size for a mip level, never below one
    function automatic int block_size(input int base, input logic [MIP_W-1:0] mip);
        int bs;
        bs = base >> mip;
        if (bs == 0)
        begin
            bs = 1;
        end
        return bs;
    endfunction

    // floor of the base-2 log of the block size, capped at 4
    function automatic logic [SHIFT_W-1:0] block_shift(input int base,
                                                       input logic [MIP_W-1:0] mip);
        int bs;
        logic [SHIFT_W-1:0] s;
        bs = block_size(base, mip);
        s  = '0;
        for (int i = 1; i <= 4; i++)
        begin
            if ((bs >> i) != 0)
            begin
                s = SHIFT_W'(i);
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ sv/lsb_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_ram: generic single-port RAM
// One write or one registered read per cycle; read data holds otherwise.
// ----------------------------------------------------------------------------
module lsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/lsb_light.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_light: bilinear light stepper
// Holds edge and running lights, steps them per texel, forms colormap address.
// ----------------------------------------------------------------------------
module lsb_light #(
    parameter int BASE_BLOCK_SIZE = lsb_pkg::BASE_BLOCK_SIZE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [lsb_pkg::MIP_W-1:0] mip_level,
    input  wire logic                      accept,
    input  wire lsb_pkg::in_item_t         item,
    output lsb_pkg::lookup_t               lookup
);
    import lsb_pkg::*;

    localparam int CNT_W = (BASE_BLOCK_SIZE > 1) ? $clog2(BASE_BLOCK_SIZE) : 1;
    localparam int SZ_W  = CNT_W + 1;

    logic [LIGHT_W-1:0] left_reg, left_next;
    logic [LIGHT_W-1:0] right_reg, right_next;
    logic [LIGHT_W-1:0] run_reg, run_next;
    logic [LIGHT_W-1:0] lstep_reg, lstep_next;
    logic [LIGHT_W-1:0] rstep_reg, rstep_next;
    logic [LIGHT_W-1:0] span_reg, span_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;

    logic [SZ_W-1:0]    bs;
    logic [SHIFT_W-1:0] shift;
    logic               row_end;
    logic               last;
    logic [LIGHT_W-1:0] left_sum;
    logic [LIGHT_W-1:0] right_sum;
    logic signed [LIGHT_W:0]   row_diff;
    logic signed [LIGHT_W:0]   row_span;
    logic signed [CORNER_W:0]  top_diff;
    logic signed [CORNER_W:0]  ldiff;
    logic signed [CORNER_W:0]  rdiff;
    logic signed [CORNER_W:0]  top_span;
    logic signed [CORNER_W:0]  lstep_new;
    logic signed [CORNER_W:0]  rstep_new;

    always_comb
    begin
        bs      = SZ_W'(block_size(BASE_BLOCK_SIZE, mip_level));
        shift   = block_shift(BASE_BLOCK_SIZE, mip_level);
        row_end = ({1'b0, col_reg} + SZ_W'(1)) >= bs;
        last    = row_end && (({1'b0, row_reg} + SZ_W'(1)) >= bs);

        left_sum  = left_reg + lstep_reg;
        right_sum = right_reg + rstep_reg;
        row_diff  = $signed({left_sum[LIGHT_W-1], left_sum})
                  - $signed({right_sum[LIGHT_W-1], right_sum});
        row_span  = row_diff >>> shift;

        top_diff  = $signed({1'b0, item.light_top_left}) - $signed({1'b0, item.light_top_right});
        ldiff     = $signed({1'b0, item.light_bottom_left}) - $signed({1'b0, item.light_top_left});
        rdiff     = $signed({1'b0, item.light_bottom_right})
                  - $signed({1'b0, item.light_top_right});
        top_span  = top_diff >>> shift;
        lstep_new = ldiff >>> shift;
        rstep_new = rdiff >>> shift;
    end

    assign lookup.addr = {run_reg[CMAP_AW-1:8], item.texel};
    assign lookup.last = last;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        run_next   = run_reg;
        lstep_next = lstep_reg;
        rstep_next = rstep_reg;
        span_next  = span_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept)
        begin
            case (item.mode)
                MODE_BLOCK_START:
                begin
                    left_next  = {2'b00, item.light_top_left};
                    right_next = {2'b00, item.light_top_right};
                    lstep_next = {lstep_new[CORNER_W], lstep_new};
                    rstep_next = {rstep_new[CORNER_W], rstep_new};
                    span_next  = {top_span[CORNER_W], top_span};
                    run_next   = {2'b00, item.light_top_right};
                    col_next   = '0;
                    row_next   = '0;
                end
                MODE_TEXEL:
                begin
                    if (row_end)
                    begin
                        col_next   = '0;
                        row_next   = last ? '0 : row_reg + CNT_W'(1);
                        left_next  = left_sum;
                        right_next = right_sum;
                        run_next   = right_sum;
                        span_next  = row_span[LIGHT_W-1:0];
                    end
                    else
                    begin
                        col_next = col_reg + CNT_W'(1);
                        run_next = run_reg + span_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            run_reg   <= '0;
            lstep_reg <= '0;
            rstep_reg <= '0;
            span_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            run_reg   <= run_next;
            lstep_reg <= lstep_next;
            rstep_reg <= rstep_next;
            span_reg  <= span_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/lit_surface_block_shader_top.sv @@
`default_nettype none
// A texel's pixel is registered at the colormap RAM read, then in the output register.
// Throughput: one transaction per clock unless the output stalls; the single colormap RAM
// port takes one write or one read per cycle. Writes and block starts give no result.
// Reset clears lights, steps, counters, mip level and valid flags; colormap RAM is not
// cleared and must be written before it is read.
// ----------------------------------------------------------------------------
// lit_surface_block_shader_top: lightmap shaded surface block
// Bilinear light stepping with colormap lookup, one shaded pixel per texel.
// ----------------------------------------------------------------------------
module lit_surface_block_shader_top #(
    parameter int BASE_BLOCK_SIZE = lsb_pkg::BASE_BLOCK_SIZE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [lsb_pkg::MIP_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire lsb_pkg::in_item_t         in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output lsb_pkg::out_item_t             out_data
);
    import lsb_pkg::*;

    logic [MIP_W-1:0] mip_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_last_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg;
    logic             in_accept;
    logic             texel_accept;
    logic             s1_advance;
    logic             ram_en;
    logic             ram_we;
    logic [CMAP_AW-1:0] ram_addr;
    logic [CMAP_DW-1:0] ram_rdata;
    lookup_t          lookup;

    lsb_light #(
        .BASE_BLOCK_SIZE (BASE_BLOCK_SIZE)
    ) u_light (
        .clk       (clk),
        .rst_n     (rst_n),
        .mip_level (mip_reg),
        .accept    (in_accept),
        .item      (in_data),
        .lookup    (lookup)
    );

    lsb_ram #(
        .WIDTH (CMAP_DW),
        .DEPTH (CMAP_DEPTH)
    ) u_cmap (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_data.cmap_value),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_advance   = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready     = !s1_valid_reg || !out_valid_reg || out_ready;
        in_accept    = in_valid && in_ready;
        texel_accept = in_accept && (in_data.mode == MODE_TEXEL);
        ram_we       = in_accept && (in_data.mode == MODE_CMAP_WRITE);
        ram_en       = ram_we || texel_accept;
        ram_addr     = ram_we ? in_data.cmap_index : lookup.addr;

        s1_valid_next = texel_accept || (s1_valid_reg && !s1_advance);
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mip_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mip_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (texel_accept)
        begin
            s1_last_reg <= lookup.last;
        end
        if (s1_advance)
        begin
            out_reg.shaded_pixel <= ram_rdata;
            out_reg.block_last   <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire
